/* rtl/rem_pkg.sv */
// ----------------------------------------------------------------------------
// rem_pkg
// Types and constants shared by the reconstruction error metrics block.
// ----------------------------------------------------------------------------
`default_nettype none

package rem_pkg;

  localparam int SampleW   = 24;   // port width of a sample
  localparam int ErrW      = 24;   // max error and rms width
  localparam int SumW      = 64;   // square sum
  localparam int CntW      = 17;   // sample count, holds up to 65536
  localparam int BaseW     = 23;   // base_value register
  localparam int RelW      = 40;   // relative rms
  localparam int SqW       = 48;   // mean square, sqrt radicand
  localparam int FracW     = 16;   // fraction bits of relative rms
  localparam int DivSteps  = 64;   // restoring divider steps
  localparam int RootSteps = 24;   // sqrt steps, two radicand bits each
  localparam int IterW     = 6;

  localparam int QDepth = 4;       // run summary queue depth
  localparam int QPtrW  = 2;
  localparam int QCntW  = 3;

  localparam int DefMaxRunLength = 65536;
  localparam int DefSampleWidth  = 24;

  localparam logic [BaseW-1:0] BaseReset = BaseW'(65536);

  typedef struct packed {
    logic signed [SampleW-1:0] ref_sample;
    logic signed [SampleW-1:0] recon_sample;
    logic                      last_flag;
  } in_item_t;

  typedef struct packed {
    logic [ErrW-1:0] max_abs_error;
    logic [ErrW-1:0] rms_error;
    logic [RelW-1:0] relative_rms;
    logic            overflow_flag;
  } out_item_t;

  // finished run handed from front to back
  typedef struct packed {
    logic [ErrW-1:0] max_err;
    logic [SumW-1:0] sq_sum;
    logic [CntW-1:0] count;
    logic            ovf;
  } run_t;

  typedef struct packed {
    logic             empty;
    logic [QCntW-1:0] count;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_ROOT,
    ST_REL,
    ST_HOLD
  } back_state_e;

endpackage

`default_nettype wire

/* rtl/rem_front.sv */
// ----------------------------------------------------------------------------
// rem_front
// Takes sample pairs, forms |ref - recon| and its square, and accumulates the
// run. On the last pair of a run it pushes the run summary to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rem_front #(
  parameter int MAX_RUN_LENGTH = rem_pkg::DefMaxRunLength,
  parameter int SAMPLE_WIDTH   = rem_pkg::DefSampleWidth
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire rem_pkg::in_item_t in_data_i,
  input  wire rem_pkg::q_stat_t  q_stat_i,
  output logic                  full_o,
  output logic                  run_push_o,
  output rem_pkg::run_t         run_o
);

  localparam int SW = SAMPLE_WIDTH;

  logic              accept;
  logic [SW-1:0]     a_s, b_s;
  logic [SW:0]       d;
  logic [SW-1:0]     diff;

  logic              s1_v_q, s1_last_q;
  logic [SW-1:0]     s1_diff_q;
  logic              s2_v_q, s2_last_q;
  logic [SW-1:0]     s2_diff_q;
  logic [2*SW-1:0]   s2_sq_q;

  logic [rem_pkg::ErrW-1:0] max_q, max_d, diff_ext, max_new;
  logic [rem_pkg::SumW-1:0] sum_q, sum_d, sum_new;
  logic [rem_pkg::CntW-1:0] cnt_q, cnt_d, cnt_new;
  logic                     ovf_q, ovf_d, ovf_new;

  logic [rem_pkg::QCntW:0]  used;

  // reserve a queue slot for every last item still in the pipe
  always_comb begin
    used = {1'b0, q_stat_i.count}
         + (rem_pkg::QCntW+1)'(s1_v_q & s1_last_q)
         + (rem_pkg::QCntW+1)'(s2_v_q & s2_last_q);
    full_o = (used >= (rem_pkg::QCntW+1)'(rem_pkg::QDepth));
  end

  assign accept = push_i & ~full_o;

  always_comb begin
    a_s  = in_data_i.ref_sample[SW-1:0];
    b_s  = in_data_i.recon_sample[SW-1:0];
    d    = {a_s[SW-1], a_s} - {b_s[SW-1], b_s};
    diff = d[SW] ? SW'(~d + 1'b1) : d[SW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_diff_q <= diff;
    s1_last_q <= in_data_i.last_flag;
    s2_diff_q <= s1_diff_q;
    s2_last_q <= s1_last_q;
    s2_sq_q   <= s1_diff_q * s1_diff_q;
  end

  // accumulate; pairs past the run limit only touch max and the flag
  always_comb begin
    diff_ext = rem_pkg::ErrW'(s2_diff_q);
    max_new  = (diff_ext > max_q) ? diff_ext : max_q;
    sum_new  = sum_q;
    cnt_new  = cnt_q;
    ovf_new  = ovf_q;
    if (cnt_q >= rem_pkg::CntW'(MAX_RUN_LENGTH)) begin
      ovf_new = 1'b1;
    end else begin
      sum_new = sum_q + rem_pkg::SumW'(s2_sq_q);
      cnt_new = cnt_q + 1'b1;
    end

    run_push_o    = s2_v_q & s2_last_q;
    run_o.max_err = max_new;
    run_o.sq_sum  = sum_new;
    run_o.count   = cnt_new;
    run_o.ovf     = ovf_new;

    max_d = max_q;
    sum_d = sum_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (s2_v_q) begin
      if (s2_last_q) begin
        max_d = '0;
        sum_d = '0;
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        max_d = max_new;
        sum_d = sum_new;
        cnt_d = cnt_new;
        ovf_d = ovf_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      max_q <= max_d;
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/rem_fifo.sv */
// ----------------------------------------------------------------------------
// rem_fifo
// Short queue of run summaries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module rem_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire rem_pkg::run_t   wdata_i,
  input  wire logic            pop_i,
  output rem_pkg::run_t        rdata_o,
  output rem_pkg::q_stat_t     stat_o
);

  rem_pkg::run_t mem [rem_pkg::QDepth];

  logic [rem_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [rem_pkg::QCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q + rem_pkg::QPtrW'(push_i);
    rd_ptr_d = rd_ptr_q + rem_pkg::QPtrW'(pop_i);
    cnt_d    = cnt_q + rem_pkg::QCntW'(push_i) - rem_pkg::QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o      = mem[rd_ptr_q];
  assign stat_o.count = cnt_q;
  assign stat_o.empty = (cnt_q == '0);

endmodule

`default_nettype wire

/* rtl/rem_back.sv */
// ----------------------------------------------------------------------------
// rem_back
// Finishes one run at a time: mean square by a restoring divider, integer
// square root two bits a step, then the relative error on the same divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rem_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rem_pkg::q_stat_t           q_stat_i,
  input  wire rem_pkg::run_t              run_i,
  input  wire logic [rem_pkg::BaseW-1:0]  base_i,
  input  wire logic                       pop_i,
  output logic                            q_pop_o,
  output logic                            empty_o,
  output rem_pkg::out_item_t              out_o
);

  rem_pkg::back_state_e state_q, state_d;

  logic [rem_pkg::IterW-1:0] it_q, it_d;
  logic [rem_pkg::SumW-1:0]  dvd_q, dvd_d, dvd_step;
  logic [rem_pkg::BaseW-1:0] rem_q, rem_d, rem_step, dvs_q, dvs_d;
  logic [rem_pkg::BaseW:0]   part, part_sub;
  logic                      qbit;

  logic [rem_pkg::SqW-1:0]   rad_q, rad_d;
  logic [rem_pkg::ErrW:0]    srem_q, srem_d, srem_step;
  logic [rem_pkg::ErrW+2:0]  sn, trial, sdiff;
  logic                      rbit;
  logic [rem_pkg::ErrW-1:0]  root_q, root_d, max_q, max_d;
  logic                      ovf_q, ovf_d;

  rem_pkg::out_item_t        out_q, out_d;
  logic                      out_v_q, out_v_d;

  // one divider step
  always_comb begin
    part     = {rem_q, dvd_q[rem_pkg::SumW-1]};
    part_sub = part - {1'b0, dvs_q};
    qbit     = (part >= {1'b0, dvs_q});
    rem_step = qbit ? part_sub[rem_pkg::BaseW-1:0] : part[rem_pkg::BaseW-1:0];
    dvd_step = {dvd_q[rem_pkg::SumW-2:0], qbit};
  end

  // one square root step
  always_comb begin
    sn        = {srem_q, rad_q[rem_pkg::SqW-1 -: 2]};
    trial     = {1'b0, root_q, 2'b01};
    sdiff     = sn - trial;
    rbit      = (sn >= trial);
    srem_step = rbit ? sdiff[rem_pkg::ErrW:0] : sn[rem_pkg::ErrW:0];
  end

  always_comb begin
    state_d = state_q;
    it_d    = it_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    rad_d   = rad_q;
    srem_d  = srem_q;
    root_d  = root_q;
    max_d   = max_q;
    ovf_d   = ovf_q;
    out_d   = out_q;
    out_v_d = out_v_q & ~pop_i;
    q_pop_o = 1'b0;

    case (state_q)
      rem_pkg::ST_IDLE: begin
        if (!q_stat_i.empty) begin
          q_pop_o = 1'b1;
          max_d   = run_i.max_err;
          ovf_d   = run_i.ovf;
          dvd_d   = run_i.sq_sum;
          dvs_d   = rem_pkg::BaseW'(run_i.count);
          rem_d   = '0;
          it_d    = '0;
          state_d = rem_pkg::ST_MEAN;
        end
      end
      rem_pkg::ST_MEAN: begin
        dvd_d = dvd_step;
        rem_d = rem_step;
        it_d  = it_q + 1'b1;
        if (it_q == rem_pkg::IterW'(rem_pkg::DivSteps - 1)) begin
          rad_d   = dvd_step[rem_pkg::SqW-1:0];
          srem_d  = '0;
          root_d  = '0;
          it_d    = '0;
          state_d = rem_pkg::ST_ROOT;
        end
      end
      rem_pkg::ST_ROOT: begin
        rad_d  = {rad_q[rem_pkg::SqW-3:0], 2'b00};
        srem_d = srem_step;
        root_d = {root_q[rem_pkg::ErrW-2:0], rbit};
        it_d   = it_q + 1'b1;
        if (it_q == rem_pkg::IterW'(rem_pkg::RootSteps - 1)) begin
          dvd_d   = rem_pkg::SumW'({root_d, rem_pkg::FracW'(0)});
          dvs_d   = base_i;
          rem_d   = '0;
          it_d    = '0;
          state_d = rem_pkg::ST_REL;
        end
      end
      rem_pkg::ST_REL: begin
        dvd_d = dvd_step;
        rem_d = rem_step;
        it_d  = it_q + 1'b1;
        // a zero base gives all ones here, the saturated value
        if (it_q == rem_pkg::IterW'(rem_pkg::DivSteps - 1)) begin
          state_d = rem_pkg::ST_HOLD;
        end
      end
      rem_pkg::ST_HOLD: begin
        if (!out_v_q || pop_i) begin
          out_d.max_abs_error = max_q;
          out_d.rms_error     = root_q;
          out_d.relative_rms  = dvd_q[rem_pkg::RelW-1:0];
          out_d.overflow_flag = ovf_q;
          out_v_d             = 1'b1;
          state_d             = rem_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rem_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rem_pkg::ST_IDLE;
      it_q    <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      it_q    <= it_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    rad_q  <= rad_d;
    srem_q <= srem_d;
    root_q <= root_d;
    max_q  <= max_d;
    ovf_q  <= ovf_d;
    out_q  <= out_d;
  end

  assign empty_o = ~out_v_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire

/* rtl/reconstruction_error_metrics_core.sv */
// ----------------------------------------------------------------------------
// reconstruction_error_metrics_core
// Max absolute error, RMS error and relative RMS over runs of sample pairs.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------
//   input    | push / full         | in_data_i  (ref, recon, last_flag)
//   result   | empty / pop         | out_data_o (max, rms, relative, ovf)
//   config   | cfg_we_i            | cfg_wdata_i (base_value)
//
// One item per cycle in while full is low; a last item reaches the queue via
// front stages s1 and s2. Per run the back pops the queue, runs 64 divider
// steps for the mean square, 24 root steps, 64 for the relative value and
// loads the result. full rises while the queue (four runs) and last items
// in the front pipe take all slots; a result waiting on pop stalls the back.
// Reset clears accumulators, queue and control; base_value becomes 65536.
// ----------------------------------------------------------------------------
`default_nettype none

module reconstruction_error_metrics_core #(
  parameter int MAX_RUN_LENGTH = rem_pkg::DefMaxRunLength,
  parameter int SAMPLE_WIDTH   = rem_pkg::DefSampleWidth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire rem_pkg::in_item_t          in_data_i,
  output logic                            empty,
  input  wire logic                       pop,
  output rem_pkg::out_item_t              out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [rem_pkg::BaseW-1:0]  cfg_wdata_i
);

  logic [rem_pkg::BaseW-1:0] base_q;
  logic                      q_push, q_pop, out_pop;
  rem_pkg::run_t             q_wdata, q_rdata;
  rem_pkg::q_stat_t          q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= rem_pkg::BaseReset;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  rem_front #(
    .MAX_RUN_LENGTH (MAX_RUN_LENGTH),
    .SAMPLE_WIDTH   (SAMPLE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .full_o     (full),
    .run_push_o (q_push),
    .run_o      (q_wdata)
  );

  rem_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  assign out_pop = pop & ~empty;

  rem_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .run_i    (q_rdata),
    .base_i   (base_q),
    .pop_i    (out_pop),
    .q_pop_o  (q_pop),
    .empty_o  (empty),
    .out_o    (out_data_o)
  );

  // slot reservation must keep the queue from overrunning
  a_q_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && !q_pop) |-> (q_stat.count != rem_pkg::QCntW'(rem_pkg::QDepth)))
    else $error("run queue overrun");

  a_q_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("run queue popped while empty");

  // a last item accepted must reach the queue after front stages s1 and s2
  a_last_reaches_q: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && in_data_i.last_flag) |=> ##1 q_push)
    else $error("last item lost in front pipe");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks reconstruction_error_metrics_core against a cycle-free predictor of
// the run metrics. Directed extreme pairs, base_value extremes (zero too),
// and random runs under random idling on both queues.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int SettleCycles   = 400;
  localparam int StallLimit     = 5000;   // cycles without any accepted item
  localparam int PhaseItems     = 240;
  localparam int IdleMax        = 10;
  localparam int MaxRun         = rem_pkg::DefMaxRunLength;
  localparam logic [rem_pkg::SampleW-1:0] SampleMax = 24'h7FFFFF;
  localparam logic [rem_pkg::SampleW-1:0] SampleMin = 24'h800000;

  // Predicts one summary per finished run and checks the results in order.
  class run_metrics_board;
    logic [rem_pkg::ErrW-1:0]  worst_diff;
    logic [rem_pkg::SumW-1:0]  sq_total;
    logic [rem_pkg::CntW-1:0]  pairs;
    bit                        over_run;
    logic [rem_pkg::BaseW-1:0] base_div;
    rem_pkg::out_item_t        pending_summaries[$];
    int                        mismatches;

    function new();
      base_div   = rem_pkg::BaseReset;
      worst_diff = '0;
      sq_total   = '0;
      pairs      = '0;
      over_run   = 1'b0;
      mismatches = 0;
    endfunction

    function void set_base(logic [rem_pkg::BaseW-1:0] v);
      base_div = v;
    endfunction

    function logic [63:0] floor_root(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] probe;
      r = '0;
      probe = 64'h1 << 62;
      while (probe > x) probe >>= 2;
      while (probe != 0) begin
        if (x >= r + probe) begin
          x -= r + probe;
          r = (r >> 1) + probe;
        end else begin
          r >>= 1;
        end
        probe >>= 2;
      end
      return r;
    endfunction

    function void note_pair(rem_pkg::in_item_t it);
      longint                   d;
      logic [rem_pkg::ErrW-1:0] mag;
      logic [rem_pkg::SumW-1:0] mean;
      logic [rem_pkg::ErrW-1:0] root;
      logic [rem_pkg::RelW-1:0] scaled;
      rem_pkg::out_item_t       s;
      d = longint'($signed(it.ref_sample)) - longint'($signed(it.recon_sample));
      mag = rem_pkg::ErrW'(d < 0 ? -d : d);
      if (mag > worst_diff) worst_diff = mag;
      // past the limit only the max keeps tracking
      if (pairs >= MaxRun) begin
        over_run = 1'b1;
      end else begin
        sq_total += rem_pkg::SumW'(mag) * rem_pkg::SumW'(mag);
        pairs++;
      end
      if (!it.last_flag) return;
      mean = (pairs != 0) ? sq_total / rem_pkg::SumW'(pairs) : '0;
      root = rem_pkg::ErrW'(floor_root(mean));
      scaled = {root, {rem_pkg::FracW{1'b0}}};
      s.max_abs_error = worst_diff;
      s.rms_error     = root;
      s.relative_rms  = (base_div == 0) ? '1 : scaled / rem_pkg::RelW'(base_div);
      s.overflow_flag = over_run;
      pending_summaries.push_back(s);
      worst_diff = '0;
      sq_total   = '0;
      pairs      = '0;
      over_run   = 1'b0;
    endfunction

    function void check_summary(rem_pkg::out_item_t got);
      rem_pkg::out_item_t want;
      if (pending_summaries.size() == 0) begin
        $error("result with no run pending: %p", got);
        mismatches++;
        return;
      end
      want = pending_summaries.pop_front();
      if (got.max_abs_error !== want.max_abs_error) begin
        $error("max_abs_error: expected %0d, got %0d", want.max_abs_error, got.max_abs_error);
        mismatches++;
      end
      if (got.rms_error !== want.rms_error) begin
        $error("rms_error: expected %0d, got %0d", want.rms_error, got.rms_error);
        mismatches++;
      end
      if (got.relative_rms !== want.relative_rms) begin
        $error("relative_rms: expected %0d, got %0d", want.relative_rms, got.relative_rms);
        mismatches++;
      end
      if (got.overflow_flag !== want.overflow_flag) begin
        $error("overflow_flag: expected %0d, got %0d", want.overflow_flag, got.overflow_flag);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      push = 1'b0;
  logic                      full;
  rem_pkg::in_item_t         in_data = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  rem_pkg::out_item_t        out_data;
  logic                      cfg_we = 1'b0;
  logic [rem_pkg::BaseW-1:0] cfg_wdata = '0;

  run_metrics_board board = new();
  int stall_cycles = 0;

  reconstruction_error_metrics_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("[reconstruction_error_metrics_core] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic rem_pkg::in_item_t make_pair(logic [rem_pkg::SampleW-1:0] a,
                                                  logic [rem_pkg::SampleW-1:0] b,
                                                  bit last);
    rem_pkg::in_item_t it;
    it.ref_sample   = a;
    it.recon_sample = b;
    it.last_flag    = last;
    return it;
  endfunction

  function automatic logic [rem_pkg::SampleW-1:0] draw_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? SampleMax : SampleMin;
      1: return rem_pkg::SampleW'($urandom_range(0, 200)) - rem_pkg::SampleW'(100);
      default: return rem_pkg::SampleW'($urandom());
    endcase
  endfunction

  function automatic int draw_run_length();
    case ($urandom_range(0, 7))
      0, 1: return $urandom_range(1, 3);
      2: return $urandom_range(41, 150);
      default: return $urandom_range(4, 40);
    endcase
  endfunction

  // push stays high after acceptance so back-to-back items need no extra edge
  task automatic send_pair(rem_pkg::in_item_t it);
    int gap;
    gap = $urandom_range(0, IdleMax);
    repeat (gap) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (full);
    board.note_pair(it);
  endtask

  task automatic hold_input(bit settle);
    push <= 1'b0;
    do @(posedge clk_i); while (board.pending_summaries.size() != 0);
    if (settle) repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_base_value(logic [rem_pkg::BaseW-1:0] v);
    hold_input(1'b1);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    board.set_base(v);
  endtask

  task automatic send_random_run(int len);
    logic [rem_pkg::SampleW-1:0] a;
    logic [rem_pkg::SampleW-1:0] b;
    for (int i = 0; i < len; i++) begin
      a = draw_sample();
      if ($urandom_range(0, 2) == 0) begin
        b = a + rem_pkg::SampleW'($urandom_range(0, 40)) - rem_pkg::SampleW'(20);
      end else begin
        b = draw_sample();
      end
      send_pair(make_pair(a, b, i == len - 1));
    end
  endtask

  initial begin : result_drain
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = $urandom_range(0, IdleMax);
      repeat (gap) begin
        pop <= 1'b0;
        @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      board.check_summary(out_data);
    end
  end

  initial begin : stimulus
    int                        sent;
    int                        len;
    logic [rem_pkg::BaseW-1:0] phase_base [6];
    logic [rem_pkg::BaseW-1:0] edge_bases [3];

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes under the reset base
    send_pair(make_pair(SampleMax, SampleMin, 1'b1));
    send_pair(make_pair(SampleMin, SampleMax, 1'b1));
    send_pair(make_pair('0, '0, 1'b1));
    send_pair(make_pair('1, '0, 1'b0));
    send_pair(make_pair(rem_pkg::SampleW'(5), -rem_pkg::SampleW'(3), 1'b0));
    send_pair(make_pair(rem_pkg::SampleW'(100), rem_pkg::SampleW'(100), 1'b0));
    send_pair(make_pair(SampleMin, SampleMin, 1'b1));
    send_pair(make_pair(SampleMax, SampleMax, 1'b0));
    send_pair(make_pair(SampleMin, '0, 1'b1));
    send_pair(make_pair(rem_pkg::SampleW'(123456), -rem_pkg::SampleW'(654321), 1'b0));
    send_pair(make_pair(rem_pkg::SampleW'(1), rem_pkg::SampleW'(2), 1'b0));
    send_pair(make_pair('0, SampleMin, 1'b0));
    send_pair(make_pair(-rem_pkg::SampleW'(5), rem_pkg::SampleW'(5), 1'b1));

    // smallest, largest and zero base (zero saturates)
    edge_bases = '{rem_pkg::BaseW'(1), '1, '0};
    foreach (edge_bases[k]) begin
      set_base_value(edge_bases[k]);
      send_pair(make_pair(SampleMax, SampleMin, 1'b1));
    end

    phase_base[0] = rem_pkg::BaseW'(1);
    phase_base[1] = '1;
    phase_base[2] = '0;
    phase_base[3] = rem_pkg::BaseW'($urandom_range(1, 8388607));
    phase_base[4] = rem_pkg::BaseW'($urandom_range(1, 255));
    phase_base[5] = rem_pkg::BaseReset;

    for (int p = 0; p < 6; p++) begin
      set_base_value(phase_base[p]);
      sent = 0;
      while (sent < PhaseItems) begin
        len = draw_run_length();
        if ($urandom_range(0, 29) == 0) hold_input(1'b0);
        send_random_run(len);
        sent += len;
      end
    end

    hold_input(1'b1);
    if (board.mismatches == 0) begin
      $display("[reconstruction_error_metrics_core] OK");
    end else begin
      $display("[reconstruction_error_metrics_core] ERROR");
    end
    $finish;
  end

endmodule
